// ===== rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and codes for the top-k subarray range sum core.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int TABLE_LEVELS_DEF = 11;

  localparam int VALUE_W = 32;
  localparam int PICK_W  = 20;
  localparam int TOTAL_W = 52;
  localparam int SPAN_W  = 33;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic                       action;
    logic signed [VALUE_W-1:0]  value;
    logic        [PICK_W-1:0]   pick_count;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [1:0]         status;
  } res_t;

endpackage

// ===== rtl/tks_ram.sv =====
// ----------------------------------------------------------------------------
// tks_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/top_k_subarray_range_sum_core.sv =====
// ----------------------------------------------------------------------------
// top_k_subarray_range_sum_core
// Loads elements, then on a run builds max/min sparse tables and sums the
// pick_count largest subarray ranges using a max-heap of candidates.
// ----------------------------------------------------------------------------
//  channel | signals                     | moves
//  --------+-----------------------------+---------------------------------
//  req     | req_valid, req_stall, req   | load one element or start a run
//  res     | res_valid, res_stall, res   | total and status, one per run
//
//  A run builds table level 0, then each further table level, then makes
//  n seed pushes and up to pick_count pops; each pop pushes its range
//  shortened by one on the right while that is not empty, and each push
//  carries its range query through the single read port of the table RAM.
//  req_stall is high for the whole run.
//  Reset clears the control state only; no RAM clearing pass is needed.
//  A finished result waits in the output register while loads continue.
// ----------------------------------------------------------------------------
module top_k_subarray_range_sum_core #(
  parameter int MAX_ELEMENTS = tks_pkg::MAX_ELEMENTS_DEF,
  parameter int TABLE_LEVELS = tks_pkg::TABLE_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tks_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output tks_pkg::res_t res
);

  import tks_pkg::*;

  localparam int IW  = $clog2(MAX_ELEMENTS);
  localparam int CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int LW  = $clog2(TABLE_LEVELS);
  localparam int LVW = $clog2(TABLE_LEVELS + 1);
  localparam int TAW = LW + IW;
  localparam int TDEPTH = TABLE_LEVELS << IW;
  localparam int HW  = SPAN_W + 2 * IW;
  localparam int LMW = 2 * CW;
  localparam int PCW = (LMW > PICK_W) ? LMW : PICK_W;

  typedef enum logic [4:0] {
    S_IDLE, S_B0_RD, S_B0_WR, S_B_CHK, S_B_RA, S_B_RB, S_B_WR,
    S_Q_INIT, S_Q_LV, S_Q_RA, S_Q_RB, S_Q_SP,
    S_PUSH_INIT, S_PUSH_CHK, S_PUSH_CMP, S_PUSH_WR,
    S_POP_CHK, S_POP_TOP, S_POP_LAST, S_SIFT_CHK, S_SIFT_RC, S_SIFT_RC2,
    S_SIFT_CMP, S_SIFT_WR, S_POP_END, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0]      count;
  logic               dropped;
  logic [CW-1:0]      n;
  logic [PICK_W-1:0]  picks;
  logic [PICK_W-1:0]  done_cnt;
  logic [1:0]         status;
  logic [TOTAL_W-1:0] total;
  logic [IW-1:0]      idx;
  logic [LVW-1:0]     lv;
  logic [CW:0]        len;
  logic [2*VALUE_W-1:0] pair_a;
  logic               seeding;
  logic [IW-1:0]      ql, qr;
  logic [LW-1:0]      qlv;
  logic [IW:0]        qstep;
  logic [HW-1:0]      nent, top, last, best;
  logic [IW-1:0]      pos, bidx;
  logic [CW-1:0]      heap_size;

  // RAM ports
  logic                 e_we;
  logic [IW-1:0]        e_waddr, e_raddr;
  logic [VALUE_W-1:0]   e_wdata, e_rdata;
  logic                 t_we;
  logic [TAW-1:0]       t_waddr, t_raddr;
  logic [2*VALUE_W-1:0] t_wdata, t_rdata;
  logic                 h_we;
  logic [IW-1:0]        h_waddr, h_raddr;
  logic [HW-1:0]        h_wdata, h_rdata;

  tks_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  tks_ram #(.WIDTH(2 * VALUE_W), .DEPTH(TDEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  tks_ram #(.WIDTH(HW), .DEPTH(MAX_ELEMENTS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // Derived values
  logic                req_acc;
  logic [LMW-1:0]      limit;
  logic [LW-1:0]       lvm1;
  logic [IW-1:0]       up;
  logic [IW:0]         qlen;
  logic [IW-1:0]       qb;
  logic [IW+1:0]       child;
  logic [IW+1:0]       size_x;
  logic signed [VALUE_W-1:0] a_mx, a_mn, b_mx, b_mn, c_mx, c_mn;
  logic [SPAN_W-1:0]   span;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign limit     = LMW'((LMW'(count) * LMW'(count + 1'b1)) >> 1);
  assign lvm1      = LW'(lv - 1'b1);
  assign up        = IW'((pos - 1'b1) >> 1);
  assign qlen      = (IW + 1)'(qr) - (IW + 1)'(ql) + 1'b1;
  assign qb        = IW'((IW + 1)'(qr) + 1'b1 - qstep);
  assign child     = {1'b0, pos, 1'b1};
  assign size_x    = (IW + 2)'(heap_size);

  assign a_mx = pair_a[2*VALUE_W-1:VALUE_W];
  assign a_mn = pair_a[VALUE_W-1:0];
  assign b_mx = t_rdata[2*VALUE_W-1:VALUE_W];
  assign b_mn = t_rdata[VALUE_W-1:0];
  assign c_mx = (b_mx > a_mx) ? b_mx : a_mx;
  assign c_mn = (b_mn < a_mn) ? b_mn : a_mn;
  assign span = SPAN_W'({c_mx[VALUE_W-1], c_mx} - {c_mn[VALUE_W-1], c_mn});

  always_comb begin
    e_we    = 1'b0;
    e_waddr = count[IW-1:0];
    e_wdata = req.value;
    e_raddr = idx;
    t_we    = 1'b0;
    t_waddr = {lv[LW-1:0], idx};
    t_wdata = {c_mx, c_mn};
    t_raddr = {lvm1, idx};
    h_we    = 1'b0;
    h_waddr = pos;
    h_wdata = nent;
    h_raddr = up;
    unique case (state)
      S_IDLE: begin
        e_we = req_acc && (req.action == ACT_LOAD) && (count < CW'(MAX_ELEMENTS));
      end
      S_B0_WR: begin
        t_we    = 1'b1;
        t_waddr = {LW'(0), idx};
        t_wdata = {e_rdata, e_rdata};
      end
      S_B_RB:  t_raddr = {lvm1, IW'(idx + IW'(len >> 1))};
      S_B_WR:  t_we = 1'b1;
      S_Q_RA:  t_raddr = {qlv, ql};
      S_Q_RB:  t_raddr = {qlv, qb};
      S_PUSH_CMP: begin
        h_we    = (h_rdata[HW-1 -: SPAN_W] < nent[HW-1 -: SPAN_W]);
        h_wdata = h_rdata;
      end
      S_PUSH_WR: h_we = 1'b1;
      S_POP_CHK: h_raddr = '0;
      S_POP_TOP: h_raddr = IW'(heap_size - 1'b1);
      S_SIFT_CHK: h_raddr = IW'(child);
      S_SIFT_RC:  h_raddr = IW'(child + 1'b1);
      S_SIFT_CMP: begin
        h_we    = (best[HW-1 -: SPAN_W] > last[HW-1 -: SPAN_W]);
        h_wdata = best;
      end
      S_SIFT_WR: begin
        h_we    = 1'b1;
        h_wdata = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      heap_size <= '0;
      res_valid <= 1'b0;
      seeding   <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req.action == ACT_LOAD) begin
              if (count < CW'(MAX_ELEMENTS)) begin
                count <= count + 1'b1;
              end else begin
                dropped <= 1'b1;
              end
            end else begin
              n        <= count;
              total    <= '0;
              done_cnt <= '0;
              idx      <= '0;
              heap_size <= '0;
              if (PCW'(req.pick_count) > PCW'(limit)) begin
                picks  <= PICK_W'(limit);
              end else begin
                picks  <= req.pick_count;
              end
              if (dropped) begin
                status <= ST_DROPPED;
              end else if (PCW'(req.pick_count) > PCW'(limit)) begin
                status <= ST_SATURATED;
              end else begin
                status <= ST_OK;
              end
              state <= (count == '0) ? S_DONE : S_B0_RD;
            end
          end
        end
        S_B0_RD: state <= S_B0_WR;
        S_B0_WR: begin
          if (CW'(idx) + 1'b1 == n) begin
            lv    <= LVW'(1);
            len   <= (CW + 1)'(2);
            state <= S_B_CHK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_B0_RD;
          end
        end
        S_B_CHK: begin
          idx <= '0;
          if (lv == LVW'(TABLE_LEVELS) || len > (CW + 1)'(n)) begin
            seeding <= 1'b1;
            ql      <= '0;
            qr      <= IW'(n - 1'b1);
            state   <= S_Q_INIT;
          end else begin
            state <= S_B_RA;
          end
        end
        S_B_RA: state <= S_B_RB;
        S_B_RB: begin
          pair_a <= t_rdata;
          state  <= S_B_WR;
        end
        S_B_WR: begin
          if ((CW + 2)'(idx) + (CW + 2)'(len) == (CW + 2)'(n)) begin
            lv    <= lv + 1'b1;
            len   <= len << 1;
            state <= S_B_CHK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_B_RA;
          end
        end
        S_Q_INIT: begin
          qlv   <= '0;
          qstep <= (IW + 1)'(1);
          state <= S_Q_LV;
        end
        S_Q_LV: begin
          // advance while the next power of two still fits the range
          if ((LVW'(qlv) + 1'b1 < LVW'(TABLE_LEVELS)) &&
              ({1'b0, qstep, 1'b0} <= (IW + 2)'(qlen))) begin
            qlv   <= qlv + 1'b1;
            qstep <= qstep << 1;
          end else begin
            state <= S_Q_RA;
          end
        end
        S_Q_RA: state <= S_Q_RB;
        S_Q_RB: begin
          pair_a <= t_rdata;
          state  <= S_Q_SP;
        end
        S_Q_SP: begin
          nent  <= {span, ql, qr};
          state <= S_PUSH_INIT;
        end
        S_PUSH_INIT: begin
          pos       <= IW'(heap_size);
          heap_size <= heap_size + 1'b1;
          state     <= S_PUSH_CHK;
        end
        S_PUSH_CHK: state <= (pos == '0) ? S_PUSH_WR : S_PUSH_CMP;
        S_PUSH_CMP: begin
          if (h_rdata[HW-1 -: SPAN_W] < nent[HW-1 -: SPAN_W]) begin
            pos   <= up;
            state <= S_PUSH_CHK;
          end else begin
            state <= S_PUSH_WR;
          end
        end
        S_PUSH_WR: begin
          if (seeding) begin
            if (CW'(idx) + 1'b1 == n) begin
              seeding <= 1'b0;
              state   <= S_POP_CHK;
            end else begin
              idx   <= idx + 1'b1;
              ql    <= idx + 1'b1;
              state <= S_Q_INIT;
            end
          end else begin
            state <= S_POP_CHK;
          end
        end
        S_POP_CHK: begin
          state <= (done_cnt < picks && heap_size != '0) ? S_POP_TOP : S_DONE;
        end
        S_POP_TOP: begin
          top       <= h_rdata;
          total     <= TOTAL_W'(total + TOTAL_W'(h_rdata[HW-1 -: SPAN_W]));
          done_cnt  <= done_cnt + 1'b1;
          heap_size <= heap_size - 1'b1;
          state     <= (heap_size == CW'(1)) ? S_POP_END : S_POP_LAST;
        end
        S_POP_LAST: begin
          last  <= h_rdata;
          pos   <= '0;
          state <= S_SIFT_CHK;
        end
        S_SIFT_CHK: state <= (child >= size_x) ? S_SIFT_WR : S_SIFT_RC;
        S_SIFT_RC: begin
          best  <= h_rdata;
          bidx  <= IW'(child);
          state <= (child + 1'b1 < size_x) ? S_SIFT_RC2 : S_SIFT_CMP;
        end
        S_SIFT_RC2: begin
          if (h_rdata[HW-1 -: SPAN_W] > best[HW-1 -: SPAN_W]) begin
            best <= h_rdata;
            bidx <= IW'(child + 1'b1);
          end
          state <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (best[HW-1 -: SPAN_W] > last[HW-1 -: SPAN_W]) begin
            pos   <= bidx;
            state <= S_SIFT_CHK;
          end else begin
            state <= S_SIFT_WR;
          end
        end
        S_SIFT_WR: state <= S_POP_END;
        S_POP_END: begin
          // push the candidate shortened by one on the right
          if (top[2*IW-1 -: IW] < top[IW-1:0]) begin
            ql    <= top[2*IW-1 -: IW];
            qr    <= top[IW-1:0] - 1'b1;
            state <= S_Q_INIT;
          end else begin
            state <= S_POP_CHK;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            res.total    <= total;
            res.status   <= status;
            count        <= '0;
            dropped      <= 1'b0;
            heap_size    <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    heap_size <= CW'(MAX_ELEMENTS))
    else $error("heap size above capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_idle_heap_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (heap_size == '0))
    else $error("heap not empty while idle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_OK || res.status == ST_DROPPED ||
                   res.status == ST_SATURATED))
    else $error("bad status code");

endmodule
